>>> rtl/core/ctd_pkg.sv
// Package for the chunked transfer decoder: codes, widths, result struct
// and the hex digit decoder. Used by every module of the block.
// No dependencies.
package ctd_pkg;

	localparam int SIZE_BITS_DEF = 31;
	localparam int CFG_W         = 31;
	localparam int HEX_BITS      = 4;
	localparam int BYTE_W        = 8;
	localparam int KIND_W        = 2;
	localparam int APB_DW        = 32;
	localparam int APB_AW        = 2;

	localparam logic [CFG_W-1:0] CFG_MAX_RESET = 31'h7FFF_FFFF;

	localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

	typedef enum logic [2:0] {
		PH_SIZE,
		PH_LF,
		PH_DATA,
		PH_DONE,
		PH_ERROR
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_DATA,
		KIND_DONE,
		KIND_ERROR
	} kind_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
		kind_t             kind;
	} result_t;

	typedef struct packed {
		logic                valid;
		logic [HEX_BITS-1:0] value;
	} hex_t;

	function automatic hex_t hex_decode(input logic [BYTE_W-1:0] c);
		hex_t h;
		h.valid = 1'b0;
		h.value = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.valid = 1'b1;
			h.value = HEX_BITS'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.valid = 1'b1;
			h.value = HEX_BITS'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.valid = 1'b1;
			h.value = HEX_BITS'(c - 8'h37);
		end
		return h;
	endfunction

endpackage

>>> rtl/core/ctd_cfg.sv
// Configuration register file for the chunked transfer decoder.
// Holds the chunk size limit and its value clipped to the size width.
// Depends on ctd_pkg.
module ctd_cfg #(
	parameter int SIZE_BITS = ctd_pkg::SIZE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ctd_pkg::APB_DW-1:0] pwdata,
	output logic [ctd_pkg::APB_DW-1:0] prdata,
	output logic [SIZE_BITS-1:0]       limit
);
	import ctd_pkg::*;

	localparam logic [CFG_W-1:0] CAP = CFG_W'((64'd1 << SIZE_BITS) - 64'd1);
	localparam logic [CFG_W-1:0] LIMIT_RESET = (CFG_MAX_RESET > CAP) ? CAP : CFG_MAX_RESET;

	logic [CFG_W-1:0] max_q;
	logic [CFG_W-1:0] wval;
	logic [SIZE_BITS-1:0] limit_q;
	logic             wr;

	assign wr   = psel && penable && pwrite;
	assign wval = pwdata[CFG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= CFG_MAX_RESET;
			limit_q <= LIMIT_RESET[SIZE_BITS-1:0];
		end else if (wr) begin
			max_q   <= wval;
			limit_q <= (wval > CAP) ? CAP[SIZE_BITS-1:0] : wval[SIZE_BITS-1:0];
		end
	end

	assign prdata = APB_DW'(max_q);
	assign limit  = limit_q;

endmodule

>>> rtl/core/ctd_core.sv
// Decoder state machine of the chunked transfer decoder: size line parsing,
// chunk data counting and error handling, one byte per step.
// Depends on ctd_pkg.
module ctd_core #(
	parameter int SIZE_BITS = ctd_pkg::SIZE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [ctd_pkg::BYTE_W-1:0] in_byte,
	input  logic                       new_message,
	input  logic [SIZE_BITS-1:0]       limit,
	output ctd_pkg::result_t           res
);
	import ctd_pkg::*;

	localparam int WIDE_W = SIZE_BITS + HEX_BITS;

	phase_t               phase_q, phase_n, ph;
	logic [SIZE_BITS-1:0] acc_q, acc_n, acc;
	logic [SIZE_BITS-1:0] left_q, left_n, left, left_m1;
	logic                 saw_q, saw_n, saw;
	logic                 ext_q, ext_n, ext;
	logic [WIDE_W-1:0]    acc_wide;
	hex_t                 hx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIZE;
			acc_q   <= '0;
			left_q  <= '0;
			saw_q   <= 1'b0;
			ext_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			left_q  <= left_n;
			saw_q   <= saw_n;
			ext_q   <= ext_n;
		end
	end

	always_comb begin
		ph       = new_message ? PH_SIZE : phase_q;
		acc      = new_message ? '0 : acc_q;
		left     = new_message ? '0 : left_q;
		saw      = new_message ? 1'b0 : saw_q;
		ext      = new_message ? 1'b0 : ext_q;
		hx       = hex_decode(in_byte);
		acc_wide = {acc, {HEX_BITS{1'b0}}} + WIDE_W'(hx.value);
		left_m1  = (left != '0) ? left - SIZE_BITS'(1) : '0;

		phase_n   = ph;
		acc_n     = acc;
		left_n    = left;
		saw_n     = saw;
		ext_n     = ext;
		res.valid = 1'b0;
		res.data  = '0;
		res.kind  = KIND_DATA;

		unique case (ph)
			PH_SIZE: begin
				if (in_byte == CH_CR) begin
					phase_n = PH_LF;
				end else if (ext) begin
					phase_n = PH_SIZE;
				end else if (hx.valid) begin
					if (acc_wide > WIDE_W'(limit)) begin
						phase_n   = PH_ERROR;
						res.valid = 1'b1;
						res.kind  = KIND_ERROR;
					end else begin
						acc_n = acc_wide[SIZE_BITS-1:0];
						saw_n = 1'b1;
					end
				end else if (!saw) begin
					phase_n   = PH_ERROR;
					res.valid = 1'b1;
					res.kind  = KIND_ERROR;
				end else begin
					ext_n = 1'b1;
				end
			end
			PH_LF: begin
				if (in_byte != CH_LF) begin
					phase_n   = PH_ERROR;
					res.valid = 1'b1;
					res.kind  = KIND_ERROR;
				end else if (!saw) begin
					phase_n = PH_SIZE;
				end else if (acc == '0) begin
					phase_n   = PH_DONE;
					res.valid = 1'b1;
					res.kind  = KIND_DONE;
				end else begin
					left_n  = acc;
					acc_n   = '0;
					saw_n   = 1'b0;
					ext_n   = 1'b0;
					phase_n = PH_DATA;
				end
			end
			PH_DATA: begin
				left_n = left_m1;
				if (left_m1 == '0) begin
					phase_n = PH_SIZE;
				end
				res.valid = 1'b1;
				res.data  = in_byte;
				res.kind  = KIND_DATA;
			end
			default: begin
				phase_n = ph;
			end
		endcase
	end

endmodule

>>> rtl/core/chunked_transfer_decoder.sv
// Top level of the chunked transfer decoder: stream ports, input stage,
// result register and configuration port.
// Depends on ctd_pkg, ctd_cfg and ctd_core.
//
// The slave stream carries one body byte per transaction, with a flag in
// s_tuser that clears the decoder before that byte is handled. The master
// stream returns at most one result per input byte: a payload byte, a
// message-complete marker or a format error, with the kind in m_tuser.
// Size line bytes, CR LF pairs and bytes after completion or an error give
// no result.
// Each byte is registered in the input stage and then decoded into the result
// register, which shows its result. One byte per cycle is sustained while
// the receiver does not stall; the rate is set by the single decode stage.
// When the receiver stalls, the held result stays and at most one more byte
// is taken into the input stage; s_tready then drops until m_tready returns.
// Reset clears the decoder to reading a size line and sets the chunk size
// limit to its largest value. The limit is written through the APB port;
// the user writes it only while the stream is idle; no logic enforces this.
module chunked_transfer_decoder #(
	parameter int SIZE_BITS = ctd_pkg::SIZE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,  // in_byte
	input  logic [0:0]                 s_tuser,  // new_message
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [7:0]                 m_tdata,  // out_byte
	output logic [1:0]                 m_tuser,  // kind
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ctd_pkg::APB_AW-1:0] paddr,
	input  logic [ctd_pkg::APB_DW-1:0] pwdata,
	output logic [ctd_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import ctd_pkg::*;

	logic                 valid_s1;
	logic [BYTE_W-1:0]    byte_s1;
	logic                 nm_s1;
	logic                 out_valid_q;
	logic [BYTE_W-1:0]    out_data_q;
	logic [KIND_W-1:0]    out_kind_q;
	logic                 advance;
	logic [SIZE_BITS-1:0] limit;
	result_t              res;

	// All registers sit at one word, so every address selects it.
	assign pready = (paddr == paddr) ? 1'b1 : 1'b0;

	ctd_cfg #(.SIZE_BITS(SIZE_BITS)) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.limit   (limit)
	);

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			nm_s1   <= s_tuser[0];
		end
	end

	ctd_core #(.SIZE_BITS(SIZE_BITS)) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.in_byte     (byte_s1),
		.new_message (nm_s1),
		.limit       (limit),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= res.data;
			out_kind_q <= res.kind;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;

endmodule

>>> rtl/core/ctd_checker.sv
// Port-level checks for the chunked transfer decoder, bound to its top level.
// Depends on ctd_pkg and chunked_transfer_decoder.
module ctd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [1:0] m_tuser,
	input logic       pready
);
	import ctd_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Stalled result transaction changed.");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == KIND_DATA || m_tuser == KIND_DONE || m_tuser == KIND_ERROR))
		else $error("Result kind out of range.");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_DATA |-> m_tdata == 8'h00)
		else $error("Marker result carries nonzero data.");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready && pready |-> s_tready)
		else $error("Input stalled while the output drains.");

endmodule

bind chunked_transfer_decoder ctd_checker u_ctd_checker (.*);
